[rtl/msrg_pkg.sv]
package msrg_pkg;

  localparam int unsigned UPDATE_INTERVAL_MS = 10;
  localparam int unsigned MS_PER_S           = 1000;
  localparam int unsigned FREQ_DIVISOR       = 15;
  localparam int unsigned FREQ_PRESHIFT      = 10;

  localparam int unsigned MUL_A_W   = 25;
  localparam int unsigned MUL_B_W   = 16;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned DEN_W     = 32;
  localparam int unsigned CNT_W     = 6;

  localparam logic [1:0] FN_TICK       = 2'd0;
  localparam logic [1:0] FN_START_RAMP = 2'd1;
  localparam logic [1:0] FN_START_SPD  = 2'd2;
  localparam logic [1:0] FN_STOP       = 2'd3;

  localparam logic [1:0] CFG_STEPS_PER_REV   = 2'd0;
  localparam logic [1:0] CFG_MICROSTEP_SHIFT = 2'd1;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        now_ms;
    logic signed [23:0] target_speed;
    logic [22:0]        ramp_rate;
  } in_item_t;

  typedef struct packed {
    logic        drive_enable;
    logic        direction;
    logic [31:0] pulse_rate;
    logic        ramp_active;
    logic        bad_rate;
  } out_item_t;

  typedef struct packed {
    logic go;
    logic is_div;
  } unit_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DUR_MUL,
    S_DUR_DIV,
    S_FRAC_DIV,
    S_STEP_MUL,
    S_APPLY,
    S_FREQ_MUL,
    S_FREQ_DIV,
    S_DONE
  } state_t;

  function automatic logic [24:0] abs25(input logic signed [24:0] x);
    abs25 = x[24] ? 25'(-x) : 25'(x);
  endfunction

endpackage

[rtl/msrg_serial_unit.sv]
module msrg_serial_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  msrg_pkg::unit_cmd_t                  cmd,
  input  logic [msrg_pkg::MUL_A_W-1:0]         op_a,
  input  logic [msrg_pkg::MUL_B_W-1:0]         op_b,
  input  logic [msrg_pkg::ACC_W-1:0]           op_num,
  input  logic [msrg_pkg::DEN_W-1:0]           op_den,
  output logic                                 done,
  output logic [msrg_pkg::ACC_W-1:0]           result
);
  import msrg_pkg::*;

  logic             busy_r, done_r, is_div_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_r, q_r[ACC_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_nxt = rem_r;
    if (is_div_r) begin
      rem_nxt = fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      q_nxt   = {q_r[ACC_W-2:0], fits};
    end else begin
      q_nxt = {q_r[ACC_W-2:0], 1'b0} + (b_r[MUL_B_W-1] ? ACC_W'(a_r) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.go) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      is_div_r <= cmd.is_div;
      cnt_r    <= cmd.is_div ? CNT_W'(ACC_W - 1) : CNT_W'(MUL_B_W - 1);
      q_r      <= cmd.is_div ? op_num : '0;
      rem_r    <= '0;
      a_r      <= op_a;
      b_r      <= op_b;
      den_r    <= op_den;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      b_r   <= {b_r[MUL_B_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done   = done_r;
  assign result = q_r;

endmodule

[rtl/motor_speed_ramp_generator.sv]
// Linear speed ramp generator for a step/direction drive: one result per
// request, handled one request at a time. Stop, and ticks that are not due or
// find no ramp, use no arithmetic. Start at speed and start ramp each run at
// most a multiply and a divide; a due ramp tick runs up to two of each, all
// on the shared bit-serial unit, which works through a multiply or a
// divide one bit per cycle.
module motor_speed_ramp_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  msrg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output msrg_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import msrg_pkg::*;

  state_t state_r, state_nxt;
  in_item_t req_r;
  logic [15:0] spr_r;
  logic [3:0]  sh_r;
  logic signed [23:0] cur_r, cur_nxt, start_r, start_nxt, goal_r, goal_nxt, spd_r, spd_nxt;
  logic [31:0] begin_r, begin_nxt, finish_r, finish_nxt, last_r, last_nxt, freq_r, freq_nxt;
  logic ramping_r, ramping_nxt, en_r, en_nxt, dir_r, dir_nxt, bad_r, bad_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  unit_cmd_t          cmd;
  logic [MUL_A_W-1:0] u_a;
  logic [MUL_B_W-1:0] u_b;
  logic [ACC_W-1:0]   u_num, u_res;
  logic [DEN_W-1:0]   u_den;
  logic               u_done;

  logic [31:0] span, elapsed;
  logic [24:0] delta_new, delta_run, step;
  logic [23:0] mag;
  logic [54:0] scaled;
  logic signed [24:0] stepped;

  msrg_serial_unit u_unit (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .op_a(u_a), .op_b(u_b),
    .op_num(u_num), .op_den(u_den), .done(u_done), .result(u_res)
  );

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    span      = finish_r - begin_r;
    elapsed   = req_r.now_ms - begin_r;
    delta_new = abs25(25'(req_r.target_speed) - 25'(cur_r));
    delta_run = abs25(25'(goal_r) - 25'(start_r));
    step      = u_res[40:16];
    stepped   = (goal_r >= start_r) ? 25'(start_r) + 25'(step) : 25'(start_r) - 25'(step);
    mag       = 24'(abs25(25'(spd_r)));
    scaled    = {16'b0, u_res[38:0]} << sh_r;
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    start_nxt   = start_r;
    goal_nxt    = goal_r;
    spd_nxt     = spd_r;
    begin_nxt   = begin_r;
    finish_nxt  = finish_r;
    last_nxt    = last_r;
    freq_nxt    = freq_r;
    ramping_nxt = ramping_r;
    en_nxt      = en_r;
    dir_nxt     = dir_r;
    bad_nxt     = bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd   = '0;
    u_a   = '0;
    u_b   = '0;
    u_num = '0;
    u_den = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
          bad_nxt   = 1'b0;
        end
      end
      S_DECODE: begin
        unique case (req_r.func)
          FN_TICK: begin
            if (!ramping_r || req_r.now_ms < last_r + 32'(UPDATE_INTERVAL_MS)) begin
              state_nxt = S_DONE;
            end else begin
              last_nxt = req_r.now_ms;
              if (req_r.now_ms > finish_r) begin
                spd_nxt     = goal_r;
                ramping_nxt = 1'b0;
                state_nxt   = S_APPLY;
              end else if (span == '0 || elapsed >= span) begin
                cmd.go    = 1'b1;
                u_a       = delta_run;
                u_b       = (span == '0) ? '0 : '1;
                state_nxt = S_STEP_MUL;
              end else begin
                cmd       = '{go: 1'b1, is_div: 1'b1};
                u_num     = {elapsed, 16'b0};
                u_den     = span;
                state_nxt = S_FRAC_DIV;
              end
            end
          end
          FN_START_RAMP: begin
            if (req_r.ramp_rate == '0) begin
              bad_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              start_nxt   = cur_r;
              goal_nxt    = req_r.target_speed;
              begin_nxt   = req_r.now_ms;
              last_nxt    = req_r.now_ms;
              ramping_nxt = 1'b1;
              cmd.go      = 1'b1;
              u_a         = delta_new;
              u_b         = MUL_B_W'(MS_PER_S);
              state_nxt   = S_DUR_MUL;
            end
          end
          FN_START_SPD: begin
            spd_nxt   = req_r.target_speed;
            state_nxt = S_APPLY;
          end
          FN_STOP: begin
            freq_nxt  = '0;
            en_nxt    = 1'b0;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DUR_MUL: begin
        if (u_done) begin
          cmd       = '{go: 1'b1, is_div: 1'b1};
          u_num     = u_res;
          u_den     = DEN_W'(req_r.ramp_rate);
          state_nxt = S_DUR_DIV;
        end
      end
      S_DUR_DIV: begin
        if (u_done) begin
          finish_nxt = ((|u_res[47:32]) ? '1 : u_res[31:0]) + begin_r;
          state_nxt  = S_DONE;
        end
      end
      S_FRAC_DIV: begin
        if (u_done) begin
          cmd.go    = 1'b1;
          u_a       = delta_run;
          u_b       = u_res[15:0];
          state_nxt = S_STEP_MUL;
        end
      end
      S_STEP_MUL: begin
        if (u_done) begin
          spd_nxt   = stepped[23:0];
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cur_nxt = spd_r;
        if (mag <= 24'd2) begin
          freq_nxt  = '0;
          en_nxt    = 1'b0;
          state_nxt = S_DONE;
        end else begin
          en_nxt    = 1'b1;
          dir_nxt   = spd_r[23];
          cmd.go    = 1'b1;
          u_a       = {1'b0, mag};
          u_b       = spr_r;
          state_nxt = S_FREQ_MUL;
        end
      end
      S_FREQ_MUL: begin
        if (u_done) begin
          cmd       = '{go: 1'b1, is_div: 1'b1};
          u_num     = ACC_W'(scaled[54:FREQ_PRESHIFT]);
          u_den     = DEN_W'(FREQ_DIVISOR);
          state_nxt = S_FREQ_DIV;
        end
      end
      S_FREQ_DIV: begin
        if (u_done) begin
          freq_nxt  = (|u_res[47:32]) ? '1 : u_res[31:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{drive_enable: en_r, direction: dir_r, pulse_rate: freq_r,
                            ramp_active: ramping_r, bad_rate: bad_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spr_r       <= 16'd200;
      sh_r        <= '0;
      cur_r       <= '0;
      start_r     <= '0;
      goal_r      <= '0;
      begin_r     <= '0;
      finish_r    <= '0;
      last_r      <= '0;
      ramping_r   <= 1'b0;
      en_r        <= 1'b0;
      dir_r       <= 1'b1;
      freq_r      <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      start_r     <= start_nxt;
      goal_r      <= goal_nxt;
      begin_r     <= begin_nxt;
      finish_r    <= finish_nxt;
      last_r      <= last_nxt;
      ramping_r   <= ramping_nxt;
      en_r        <= en_nxt;
      dir_r       <= dir_nxt;
      freq_r      <= freq_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_index == CFG_STEPS_PER_REV) begin
        spr_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_MICROSTEP_SHIFT) begin
        sh_r <= cfg_data[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    spd_r      <= spd_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DECODE)
    else $error("accepted request did not start decoding");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (state_r == S_DUR_MUL || state_r == S_DUR_DIV || state_r == S_FRAC_DIV ||
                state_r == S_STEP_MUL || state_r == S_FREQ_MUL || state_r == S_FREQ_DIV))
    else $error("serial unit finished outside a wait state");
  a_freq_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    freq_r != '0 |-> en_r)
    else $error("step frequency nonzero with drive disabled");
`endif

endmodule
